/* sv/dprt_pkg.sv */
// ----------------------------------------------------------------------------
// dprt_pkg
// Types, codes and fixed tables of the device permission rule table.
// ----------------------------------------------------------------------------
package dprt_pkg;

  localparam logic [31:0] MINOR_MASK = 32'h000F_FFFF;

  localparam logic [1:0] GRAN_ALL   = 2'd0;
  localparam logic [1:0] GRAN_MAJOR = 2'd1;
  localparam logic [1:0] GRAN_MINOR = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DENY   = 2'd1;
  localparam logic [1:0] ST_NORULE = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAN = 2'd2,
    OP_NONE  = 2'd3
  } dprt_op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] env_id;
    logic        dev_kind;
    logic [31:0] device_number;
    logic [1:0]  rule_granularity;
    logic [7:0]  rule_mask;
    logic [2:0]  req_mode;
    logic        use_defaults;
  } dprt_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] matched_mask;
  } dprt_out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] env;
    logic [31:0] dev;
    logic [7:0]  mask;
    logic [1:0]  gran;
    logic        kind;
  } dprt_entry_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_DRAIN, S_COMMIT, S_RESP
  } dprt_state_t;

  typedef struct packed {
    logic init_wr;
    logic load;
    logic rd_en;
    logic commit;
  } dprt_cmd_t;

  typedef struct packed {
    logic is_set;
  } dprt_stat_t;

  function automatic logic [7:0] mode_to_mask(input logic [2:0] mode);
    return {4'd0, mode[2], mode[0], mode[1], 1'b0};
  endfunction

  function automatic logic [31:0] mkdev(input logic [11:0] ma, input logic [19:0] mi);
    return {ma, mi};
  endfunction

  // fixed char-device defaults
  function automatic logic [7:0] default_mask(input logic [31:0] dev);
    logic [11:0] ma;
    ma = dev[31:20];
    if (dev == mkdev(12'd1, 20'd3) || dev == mkdev(12'd1, 20'd5) ||
        dev == mkdev(12'd1, 20'd7) || dev == mkdev(12'd5, 20'd0) ||
        dev == mkdev(12'd5, 20'd2))
      return 8'd6;
    if (dev == mkdev(12'd1, 20'd8) || dev == mkdev(12'd1, 20'd9))
      return 8'd4;
    if (ma == 12'd128 || ma == 12'd136 || ma == 12'd2 || ma == 12'd3)
      return 8'd6;
    return 8'd0;
  endfunction

endpackage

/* sv/dprt_ctrl.sv */
// ----------------------------------------------------------------------------
// dprt_ctrl
// Sequencer: reset fill pass, table scan, commit and response handshake.
// ----------------------------------------------------------------------------
module dprt_ctrl import dprt_pkg::*; #(
  parameter int RULE_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  output logic                            out_valid,
  input  logic                            out_stall,
  input  dprt_stat_t                      stat,
  output dprt_cmd_t                       cmd,
  output logic [$clog2(RULE_ENTRIES)-1:0] idx
);
  localparam int IW = $clog2(RULE_ENTRIES);

  dprt_state_t state, state_next;
  logic [IW-1:0] idx_next;
  logic last;

  assign last = (idx == IW'(RULE_ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        idx_next    = last ? '0 : idx + 1'b1;
        if (last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          idx_next   = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        idx_next  = last ? '0 : idx + 1'b1;
        if (last) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_COMMIT;
      S_COMMIT: begin
        cmd.commit = stat.is_set || 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* sv/dprt_dp.sv */
// ----------------------------------------------------------------------------
// dprt_dp
// Rule memory, item register, scan compare and result register.
// ----------------------------------------------------------------------------
module dprt_dp import dprt_pkg::*; #(
  parameter int RULE_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dprt_in_t                        in_word,
  input  dprt_cmd_t                       cmd,
  input  logic [$clog2(RULE_ENTRIES)-1:0] idx,
  output dprt_stat_t                      stat,
  output dprt_out_t                       out_word
);
  localparam int IW = $clog2(RULE_ENTRIES);

  dprt_entry_t mem [RULE_ENTRIES];
  dprt_entry_t rd_q, wd, init_e;
  logic [IW-1:0] wa, cmp_idx;
  logic we, cmp_vld;

  dprt_in_t item;
  logic [31:0] ndev;

  logic f_min, f_maj, f_all, f_set, f_free;
  logic [7:0] mk_min, mk_maj, mk_all;
  logic [IW-1:0] i_set, i_free;

  logic base, m_min, m_maj, m_all, m_set, m_env;
  dprt_out_t res;
  logic [7:0] mk, need;
  logic found;

  assign stat.is_set = (item.operation == OP_SET);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_word;
      unique case (in_word.rule_granularity)
        GRAN_ALL:   ndev <= '0;
        GRAN_MAJOR: ndev <= in_word.device_number & ~MINOR_MASK;
        default:    ndev <= in_word.device_number;
      endcase
    end
  end

  // memory: one read and one write port
  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_q <= mem[idx];
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (rst) cmp_vld <= 1'b0;
    else     cmp_vld <= cmd.rd_en;
    cmp_idx <= idx;
  end

  always_comb begin
    m_env = rd_q.valid && rd_q.env == item.env_id;
    base  = m_env && rd_q.kind == item.dev_kind;
    m_min = base && rd_q.gran == GRAN_MINOR && rd_q.dev == item.device_number;
    m_maj = base && rd_q.gran == GRAN_MAJOR &&
            rd_q.dev == (item.device_number & ~MINOR_MASK);
    m_all = base && rd_q.gran == GRAN_ALL && rd_q.dev == '0;
    m_set = base && rd_q.gran == item.rule_granularity && rd_q.dev == ndev;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      f_min  <= 1'b0;
      f_maj  <= 1'b0;
      f_all  <= 1'b0;
      f_set  <= 1'b0;
      f_free <= 1'b0;
    end else if (cmp_vld) begin
      if (m_min && !f_min) begin
        f_min <= 1'b1; mk_min <= rd_q.mask;
      end
      if (m_maj && !f_maj) begin
        f_maj <= 1'b1; mk_maj <= rd_q.mask;
      end
      if (m_all && !f_all) begin
        f_all <= 1'b1; mk_all <= rd_q.mask;
      end
      if (m_set && !f_set) begin
        f_set <= 1'b1; i_set <= cmp_idx;
      end
      if (!rd_q.valid && !f_free) begin
        f_free <= 1'b1; i_free <= cmp_idx;
      end
    end
  end

  always_comb begin
    init_e = '0;
    if (idx == IW'(0)) begin
      init_e.valid = 1'b1; init_e.kind = 1'b0; init_e.gran = GRAN_ALL; init_e.mask = 8'd6;
    end else if (idx == IW'(1)) begin
      init_e.valid = 1'b1; init_e.kind = 1'b1; init_e.gran = GRAN_ALL; init_e.mask = 8'd14;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = idx;
    wd = init_e;
    if (cmd.init_wr) begin
      we = 1'b1;
    end else if (cmp_vld && item.operation == OP_CLEAN && m_env) begin
      we = 1'b1;
      wa = cmp_idx;
      wd = rd_q;
      wd.valid = 1'b0;
    end else if (cmd.commit && item.operation == OP_SET &&
                 item.rule_granularity <= GRAN_MINOR && (f_set || f_free)) begin
      we      = 1'b1;
      wa      = f_set ? i_set : i_free;
      wd.valid = 1'b1;
      wd.env  = item.env_id;
      wd.dev  = ndev;
      wd.mask = item.rule_mask;
      wd.gran = item.rule_granularity;
      wd.kind = item.dev_kind;
    end
  end

  always_comb begin
    res   = '0;
    found = 1'b1;
    mk    = 8'd0;
    need  = mode_to_mask(item.req_mode);
    if (f_min)       mk = mk_min;
    else if (f_maj)  mk = mk_maj;
    else if (f_all)  mk = mk_all;
    else if (item.use_defaults) mk = item.dev_kind ? 8'd0 : default_mask(item.device_number);
    else found = 1'b0;
    unique case (item.operation)
      OP_CHECK: begin
        if (!found) begin
          res.status = ST_NORULE;
        end else begin
          res.matched_mask = mk;
          res.status = ((mk & need) == need) ? ST_OK : ST_DENY;
        end
      end
      OP_SET: begin
        if (item.rule_granularity <= GRAN_MINOR && !f_set && !f_free) res.status = ST_FULL;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_word <= res;
  end

endmodule

/* sv/device_permission_rule_table.sv */
// ----------------------------------------------------------------------------
// device_permission_rule_table
// Device permission rules: check, set and clean over a scanned rule memory.
// ----------------------------------------------------------------------------
// channel | signals                     | payload
// input   | in_valid / in_stall         | in_word  (dprt_in_t)
// output  | out_valid / out_stall       | out_word (dprt_out_t)
//
// One item at a time: no word is accepted until the result is taken. The scan
// reads the rule memory through its one read port, one entry per cycle.
// After reset a fill pass over all RULE_ENTRIES entries loads the two base rules and
// clears the rest; no word is accepted meanwhile.
// A result is held in its register until taken.
// ----------------------------------------------------------------------------
module device_permission_rule_table import dprt_pkg::*; #(
  parameter int RULE_ENTRIES = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  dprt_in_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output dprt_out_t out_word
);
  dprt_cmd_t  cmd;
  dprt_stat_t stat;
  logic [$clog2(RULE_ENTRIES)-1:0] idx;

  dprt_ctrl #(.RULE_ENTRIES(RULE_ENTRIES)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .cmd, .idx
  );

  dprt_dp #(.RULE_ENTRIES(RULE_ENTRIES)) u_dp (
    .clk, .rst, .in_word, .cmd, .idx, .stat, .out_word
  );

  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result pending");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall) else $error("second word taken");

  a_zero_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.status == ST_NORULE || out_word.status == ST_FULL)
      |-> out_word.matched_mask == 8'd0) else $error("mask on no-rule result");

endmodule

/* verif/tb_device_permission_rule_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_device_permission_rule_table
// Drives check, set and clean words into the rule table with random gaps on
// both channels. A local model of the rule memory predicts every result,
// and each output word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_device_permission_rule_table;
  import dprt_pkg::*;

  localparam int ENTRIES = 64;
  localparam int IDLE_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  dprt_in_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  dprt_out_t out_word;

  bit          rule_vld [ENTRIES];
  logic [31:0] rule_env [ENTRIES];
  logic [31:0] rule_dev [ENTRIES];
  logic [1:0]  rule_gran [ENTRIES];
  logic        rule_kind [ENTRIES];
  logic [7:0]  rule_mask [ENTRIES];

  dprt_out_t expected_q[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;

  device_permission_rule_table #(.RULE_ENTRIES(ENTRIES)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word)
  );

  always #10 clk = ~clk;

  task automatic reset_rules();
    for (int i = 0; i < ENTRIES; i++) begin
      rule_vld[i] = 0; rule_env[i] = '0; rule_dev[i] = '0;
      rule_gran[i] = GRAN_ALL; rule_kind[i] = 0; rule_mask[i] = '0;
    end
    rule_vld[0] = 1; rule_mask[0] = 8'd6;
    rule_vld[1] = 1; rule_kind[1] = 1; rule_mask[1] = 8'd14;
  endtask

  function automatic int find_rule(logic [31:0] env, logic kind, logic [1:0] gran,
                                   logic [31:0] dev);
    for (int i = 0; i < ENTRIES; i++)
      if (rule_vld[i] && rule_env[i] == env && rule_kind[i] == kind &&
          rule_gran[i] == gran && rule_dev[i] == dev)
        return i;
    return -1;
  endfunction

  function automatic logic [7:0] builtin_mask(logic [31:0] dev);
    logic [11:0] ma;
    ma = dev[31:20];
    if (dev == {12'd1, 20'd3} || dev == {12'd1, 20'd5} || dev == {12'd1, 20'd7} ||
        dev == {12'd5, 20'd0} || dev == {12'd5, 20'd2})
      return 8'd6;
    if (dev == {12'd1, 20'd8} || dev == {12'd1, 20'd9}) return 8'd4;
    if (ma == 12'd128 || ma == 12'd136 || ma == 12'd2 || ma == 12'd3) return 8'd6;
    return 8'd0;
  endfunction

  function automatic dprt_out_t apply_rule_op(dprt_in_t w);
    dprt_out_t r;
    int idx;
    int slot;
    logic [31:0] ndev;
    logic [7:0] need;
    r = '0;
    case (dprt_op_t'(w.operation))
      OP_CHECK: begin
        idx = find_rule(w.env_id, w.dev_kind, GRAN_MINOR, w.device_number);
        if (idx < 0)
          idx = find_rule(w.env_id, w.dev_kind, GRAN_MAJOR, w.device_number & ~MINOR_MASK);
        if (idx < 0) idx = find_rule(w.env_id, w.dev_kind, GRAN_ALL, '0);
        need = {4'd0, w.req_mode[2], w.req_mode[0], w.req_mode[1], 1'b0};
        if (idx >= 0 || w.use_defaults) begin
          if (idx >= 0) r.matched_mask = rule_mask[idx];
          else r.matched_mask = w.dev_kind ? 8'd0 : builtin_mask(w.device_number);
          r.status = ((r.matched_mask & need) == need) ? ST_OK : ST_DENY;
        end else begin
          r.status = ST_NORULE;
        end
      end
      OP_SET: begin
        if (w.rule_granularity <= GRAN_MINOR) begin
          ndev = (w.rule_granularity == GRAN_ALL) ? 32'd0 :
                 (w.rule_granularity == GRAN_MAJOR) ? (w.device_number & ~MINOR_MASK) :
                 w.device_number;
          idx = find_rule(w.env_id, w.dev_kind, w.rule_granularity, ndev);
          if (idx >= 0) begin
            rule_mask[idx] = w.rule_mask;
          end else begin
            slot = -1;
            for (int i = 0; i < ENTRIES; i++)
              if (!rule_vld[i] && slot < 0) slot = i;
            if (slot < 0) r.status = ST_FULL;
            else begin
              rule_vld[slot] = 1; rule_env[slot] = w.env_id; rule_dev[slot] = ndev;
              rule_gran[slot] = w.rule_granularity; rule_kind[slot] = w.dev_kind;
              rule_mask[slot] = w.rule_mask;
            end
          end
        end
      end
      OP_CLEAN: begin
        for (int i = 0; i < ENTRIES; i++)
          if (rule_vld[i] && rule_env[i] == w.env_id) rule_vld[i] = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(dprt_in_t w);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(apply_rule_op(w));
  endtask

  function automatic dprt_in_t rand_word();
    dprt_in_t w;
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    w = bits[$bits(dprt_in_t)-1:0];
    return w;
  endfunction

  // result checker with random receive stalls
  initial begin
    dprt_out_t exp_w;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall && !rst) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_word);
        end else begin
          exp_w = expected_q.pop_front();
          if (out_word.status !== exp_w.status ||
              out_word.matched_mask !== exp_w.matched_mask) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp status %0d mask %h, got status %0d mask %h",
                       exp_w.status, exp_w.matched_mask, out_word.status,
                       out_word.matched_mask);
          end
        end
      end
      @(negedge clk);
      if (!quiet && !out_stall && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic dprt_in_t mk(dprt_op_t op, logic [31:0] env, logic kind,
                                  logic [31:0] dev, logic [1:0] gran, logic [7:0] mask,
                                  logic [2:0] mode, logic defs);
    dprt_in_t w;
    w.operation = op; w.env_id = env; w.dev_kind = kind; w.device_number = dev;
    w.rule_granularity = gran; w.rule_mask = mask; w.req_mode = mode;
    w.use_defaults = defs;
    return w;
  endfunction

  task automatic test_directed();
    send_word(mk(OP_CHECK, 0, 0, 32'h0010_0003, GRAN_ALL, 0, 3'd3, 0));
    send_word(mk(OP_CHECK, 0, 1, '1, GRAN_ALL, 0, 3'd7, 0));
    send_word(mk(OP_CHECK, 5, 0, 32'h0010_0003, GRAN_ALL, 0, 3'd3, 1));
    send_word(mk(OP_CHECK, 5, 0, 32'h0010_0008, GRAN_ALL, 0, 3'd2, 1));
    send_word(mk(OP_CHECK, 5, 0, 32'h8800_1234, GRAN_ALL, 0, 3'd3, 1));
    send_word(mk(OP_CHECK, 5, 1, 32'h0010_0003, GRAN_ALL, 0, 3'd1, 1));
    send_word(mk(OP_CHECK, 5, 1, 32'h0010_0003, GRAN_ALL, 0, 3'd0, 1));
    send_word(mk(OP_CHECK, 5, 0, 0, GRAN_ALL, 0, 3'd0, 0));
    send_word(mk(OP_SET, 5, 0, 32'h0030_0007, GRAN_MINOR, 8'hff, 0, 0));
    send_word(mk(OP_SET, 5, 0, 32'h0030_0abc, GRAN_MAJOR, 8'h04, 0, 0));
    send_word(mk(OP_SET, 5, 0, 32'h0030_0def, GRAN_MAJOR, 8'h0c, 0, 0));
    send_word(mk(OP_SET, 5, 0, '1, GRAN_ALL, 8'h00, 0, 0));
    send_word(mk(OP_SET, 5, 0, '1, 2'd3, 8'h55, 0, 0));
    send_word(mk(OP_CHECK, 5, 0, 32'h0030_0007, GRAN_ALL, 0, 3'd7, 0));
    send_word(mk(OP_CHECK, 5, 0, 32'h0030_0001, GRAN_ALL, 0, 3'd5, 0));
    send_word(mk(OP_CHECK, 5, 0, 32'h0040_0001, GRAN_ALL, 0, 3'd1, 0));
    send_word(mk(OP_NONE, '1, 1, '1, 2'd3, '1, '1, 1));
    send_word(mk(OP_CLEAN, 5, 0, 0, GRAN_ALL, 0, 0, 0));
    send_word(mk(OP_CHECK, 5, 0, 32'h0030_0007, GRAN_ALL, 0, 3'd1, 0));
    send_word(mk(OP_CLEAN, 0, 0, 0, GRAN_ALL, 0, 0, 0));
    send_word(mk(OP_CHECK, 0, 0, 32'h0010_0003, GRAN_ALL, 0, 3'd1, 0));
  endtask

  task automatic test_table_full();
    for (int i = 0; i < ENTRIES + 2; i++)
      send_word(mk(OP_SET, 32'hffff_fff0, i[0], {i[11:0], 20'd1}, GRAN_MINOR,
                   8'($urandom), 0, 0));
    send_word(mk(OP_CHECK, 32'hffff_fff0, 1, {12'd3, 20'd1}, GRAN_ALL, 0, 3'd7, 0));
    send_word(mk(OP_CLEAN, 32'hffff_fff0, 0, 0, GRAN_ALL, 0, 0, 0));
  endtask

  task automatic test_random(int count);
    dprt_in_t w;
    for (int n = 0; n < count; n++) begin
      w = rand_word();
      if ($urandom_range(0, 9) != 0) begin
        // keep keys in a narrow space so sets and checks meet
        w.env_id = $urandom_range(0, 3);
        w.device_number = {10'd0, 2'($urandom_range(0, 3)), 18'd0,
                           2'($urandom_range(0, 3))};
        if ($urandom_range(0, 7) == 0) w.device_number = {12'd1, 20'($urandom_range(0, 9))};
        w.operation = ($urandom_range(0, 19) == 0) ? OP_CLEAN :
                      ($urandom_range(0, 2) == 0) ? OP_SET : OP_CHECK;
        if (w.operation == OP_SET && $urandom_range(0, 9) != 0)
          w.rule_granularity = 2'($urandom_range(0, 2));
      end
      send_word(w);
    end
  endtask

  initial begin
    int drain;
    reset_rules();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_table_full();
    test_random(220);
    quiet = 1'b1;
    test_random(100);
    @(negedge clk);
    in_valid <= 1'b0;
    drain = 0;
    while (expected_q.size() != 0 && drain < 50000) begin
      @(posedge clk);
      drain++;
    end
    repeat (ENTRIES + 10) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
